[design/crms_pkg.sv]
// Shared widths, constants and inter-module beat types of the complex RMS estimator.
package crms_pkg;

  // Sample and arithmetic widths.
  localparam int SampleBits = 16;
  localparam int MagBits    = 2 * SampleBits;
  localparam int FracBits   = 16;
  localparam int AlphaBits  = FracBits + 1;
  localparam int PowerBits  = MagBits + FracBits;
  localparam int RmsBits    = PowerBits / 2;

  // Smoothing gain: unity in Q1.16 and the value after reset.
  localparam logic [AlphaBits-1:0] AlphaOne   = {1'b1, {FracBits{1'b0}}};
  localparam logic [AlphaBits-1:0] AlphaReset = AlphaBits'(7);

  // Depth of the queue between the front end and the back end.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Magnitude-squared beat from the front end towards the filter.
  typedef struct packed {
    logic               valid;
    logic [MagBits-1:0] magsq;
  } mag_beat_t;

  // Smoothed power beat from the filter towards the square-root unit.
  typedef struct packed {
    logic                 valid;
    logic [PowerBits-1:0] power;
  } power_beat_t;

endpackage

[design/complex_rms_estimator.sv]
// Complex RMS estimator top level: sample queue front end, IIR power filter and square root.
//
// Each accepted complex sample (I, Q) yields one result, floor(sqrt(P)), where P is the
// Q32.16 power smoothed by P += alpha*(I*I+Q*Q - P) with alpha in Q1.16. The front end
// squares a sample into a register and queues up to four magnitudes, so short bursts
// are taken at one beat per clock while the queue has room. In the back end each item
// passes the filter steps (difference, split 17x49 product, product sum, power update,
// hand-over) and then the bit-serial square-root unit, one result bit per cycle, and its
// result register; the square-root unit takes a new power only once its result is popped
// and sets the sustained rate. Alpha writes above 1.0 saturate to 1.0; reset gives 7/65536.
module complex_rms_estimator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [crms_pkg::SampleBits-1:0] i_sample_i,
  input  logic signed [crms_pkg::SampleBits-1:0] q_sample_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [crms_pkg::RmsBits-1:0]           rms_out_o,
  input  logic                                   alpha_we_i,
  input  logic [crms_pkg::AlphaBits-1:0]         alpha_i
);

  logic [crms_pkg::AlphaBits-1:0] alpha_q;
  crms_pkg::mag_beat_t            front_mag, queue_mag;
  crms_pkg::power_beat_t          iir_pow;
  logic                           queue_ready, iir_ready, sqrt_ready;

  // Gain register; values above unity saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= crms_pkg::AlphaReset;
    end else if (alpha_we_i) begin
      alpha_q <= (alpha_i > crms_pkg::AlphaOne) ? crms_pkg::AlphaOne : alpha_i;
    end
  end

  // Front end.
  crms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .i_sample_i  (i_sample_i),
    .q_sample_i  (q_sample_i),
    .mag_o       (front_mag),
    .mag_ready_i (queue_ready)
  );

  // Queue between the two halves.
  crms_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (front_mag),
    .wr_ready_o (queue_ready),
    .rd_o       (queue_mag),
    .rd_ready_i (iir_ready)
  );

  // Power filter.
  crms_iir u_iir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mag_i       (queue_mag),
    .mag_ready_o (iir_ready),
    .alpha_i     (alpha_q),
    .pow_o       (iir_pow),
    .pow_ready_i (sqrt_ready)
  );

  // Square root and result register.
  crms_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pow_i       (iir_pow),
    .pow_ready_o (sqrt_ready),
    .rms_o       (rms_out_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[design/crms_front.sv]
// Front end: accepts complex samples, squares both parts and forms the magnitude squared.
module crms_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic signed [crms_pkg::SampleBits-1:0] i_sample_i,
  input  logic signed [crms_pkg::SampleBits-1:0] q_sample_i,
  output crms_pkg::mag_beat_t                 mag_o,
  input  logic                                mag_ready_i
);

  localparam int SqBits = crms_pkg::MagBits - 1;

  logic              valid_q, valid_d;
  logic [SqBits-1:0] isq_q, qsq_q;
  logic              accept;
  logic              stalled;

  // The square stage holds its beat while the queue is full.
  assign stalled = valid_q && !mag_ready_i;
  assign full_o  = stalled;
  assign accept  = push_i && !full_o;
  assign valid_d = accept || stalled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Squares of both parts; each is non-negative and at most 2^(2*SampleBits-2).
  always_ff @(posedge clk_i) begin
    if (accept) begin
      isq_q <= SqBits'(i_sample_i * i_sample_i);
      qsq_q <= SqBits'(q_sample_i * q_sample_i);
    end
  end

  // The sum of the squares goes to the queue.
  assign mag_o.valid = valid_q;
  assign mag_o.magsq = {1'b0, isq_q} + {1'b0, qsq_q};

endmodule

[design/crms_fifo.sv]
// Short queue of magnitude-squared beats between the front end and the back end.
module crms_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crms_pkg::mag_beat_t wr_i,
  output logic                wr_ready_o,
  output crms_pkg::mag_beat_t rd_o,
  input  logic                rd_ready_i
);

  logic [crms_pkg::MagBits-1:0] mem_q [crms_pkg::FifoDepth];
  logic [crms_pkg::FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [crms_pkg::FifoAw:0]    count_q;
  logic                         do_wr, do_rd;

  assign wr_ready_o = count_q != (crms_pkg::FifoAw + 1)'(crms_pkg::FifoDepth);
  assign rd_o.valid = count_q != '0;
  assign rd_o.magsq = mem_q[rd_ptr_q];

  assign do_wr = wr_i.valid && wr_ready_o;
  assign do_rd = rd_o.valid && rd_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_i.magsq;
    end
  end

endmodule

[design/crms_iir.sv]
// Back end, first part: single-pole IIR update of the smoothed power.
module crms_iir (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  crms_pkg::mag_beat_t                 mag_i,
  output logic                                mag_ready_o,
  input  logic [crms_pkg::AlphaBits-1:0]      alpha_i,
  output crms_pkg::power_beat_t               pow_o,
  input  logic                                pow_ready_i
);

  localparam int PB      = crms_pkg::PowerBits;
  localparam int DLoBits = PB / 2;
  localparam int DHiBits = PB + 1 - DLoBits;
  localparam int PlBits  = crms_pkg::AlphaBits + DLoBits;
  localparam int PhBits  = crms_pkg::AlphaBits + 1 + DHiBits;
  localparam int ProdBits = PB + crms_pkg::FracBits;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StHand = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [PB-1:0]            power_q;
  logic signed [PB:0]       diff_q;
  logic [PlBits-1:0]        pl_q;
  logic signed [PhBits-1:0] ph_q;
  logic [ProdBits-1:0]      prod_q;
  logic [PB-1:0]            target;

  assign target      = {mag_i.magsq, {crms_pkg::FracBits{1'b0}}};
  assign mag_ready_o = state_q == StIdle;
  assign pow_o.valid = state_q == StHand;
  assign pow_o.power = power_q;

  // Sequencer: difference, split product, product sum, power update, hand-over.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (mag_i.valid) begin
          state_d = StMul;
        end
      end
      StMul:  state_d = StSum;
      StSum:  state_d = StUpd;
      StUpd:  state_d = StHand;
      StHand: begin
        if (pow_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      power_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StUpd) begin
        // Arithmetic shift by the fraction width rounds towards minus infinity.
        power_q <= power_q + prod_q[ProdBits-1:crms_pkg::FracBits];
      end
    end
  end

  // Datapath: the 17 by 49 bit product is cut into a low and a high partial product.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && mag_i.valid) begin
      diff_q <= $signed({1'b0, target}) - $signed({1'b0, power_q});
    end
    if (state_q == StMul) begin
      pl_q <= alpha_i * diff_q[DLoBits-1:0];
      ph_q <= $signed({1'b0, alpha_i}) * $signed(diff_q[PB:DLoBits]);
    end
    if (state_q == StSum) begin
      prod_q <= (ProdBits'(ph_q) << DLoBits) + ProdBits'(pl_q);
    end
  end

endmodule

[design/crms_sqrt.sv]
// Back end, second part: bit-serial integer square root and the result register.
module crms_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  crms_pkg::power_beat_t              pow_i,
  output logic                               pow_ready_o,
  output logic [crms_pkg::RmsBits-1:0]       rms_o,
  output logic                               empty_o,
  input  logic                               pop_i
);

  localparam int PB       = crms_pkg::PowerBits;
  localparam int RB       = crms_pkg::RmsBits;
  localparam int RemBits  = RB + 2;
  localparam int ShBits   = RB + 4;
  localparam int CntBits  = $clog2(RB);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [PB-1:0]      x_q;
  logic [RemBits-1:0] rem_q;
  logic [RB-1:0]      root_q;
  logic [CntBits-1:0] cnt_q;
  logic [ShBits-1:0]  rem_sh, trial, rem_sub;
  logic               ge;

  assign pow_ready_o = state_q == StIdle;
  assign empty_o     = state_q != StDone;
  assign rms_o       = root_q;

  // One result bit per cycle: bring down two bits, try to subtract 4*root+1.
  assign rem_sh  = {rem_q, x_q[PB-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (pow_i.valid) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (pop_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle) begin
        cnt_q <= CntBits'(RB - 1);
      end else if (state_q == StRun) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Radicand, partial remainder and root.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && pow_i.valid) begin
      x_q    <= pow_i.power;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == StRun) begin
      x_q    <= {x_q[PB-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[RemBits-1:0] : rem_sh[RemBits-1:0];
      root_q <= {root_q[RB-2:0], ge};
    end
  end

endmodule

[design/crms_checker.sv]
// Port-level checker for the complex RMS estimator and its bind statement.
module crms_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [crms_pkg::RmsBits-1:0] rms_out_o
);

  localparam logic [crms_pkg::RmsBits-1:0] RmsMax = crms_pkg::RmsBits'(11863283);

  logic [3:0] outstanding_q;
  logic       in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // Items accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_beat && !out_beat) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rms_out_o))
    else $error("result changed or vanished before it was taken");

  // No result without an item in flight, and no back-pressure with nothing in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outstanding_q != '0)
    else $error("result shown with no item outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q == '0 |-> !full)
    else $error("input full while the block is idle");

  // A taken beat sends the square-root unit back to idle, so it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |=> empty)
    else $error("new result followed a taken beat immediately");

  // The root of the largest possible power bounds every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> rms_out_o <= RmsMax)
    else $error("result above the largest possible root");

endmodule

bind complex_rms_estimator crms_checker u_crms_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .rms_out_o (rms_out_o)
);

[tb/tb_complex_rms_estimator.sv]
// Self-checking testbench of the complex RMS estimator: directed and random sample beats.
module tb_complex_rms_estimator;

  localparam int MaxReports = 10;
  localparam int TailCycles = 64;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   push;
  logic                                   full;
  logic signed [crms_pkg::SampleBits-1:0] i_sample_i;
  logic signed [crms_pkg::SampleBits-1:0] q_sample_i;
  logic                                   empty;
  logic                                   pop;
  logic [crms_pkg::RmsBits-1:0]           rms_out_o;
  logic                                   alpha_we_i;
  logic [crms_pkg::AlphaBits-1:0]         alpha_i;

  // Predictor state: smoothed power in Q32.16 and the saturated gain.
  logic [crms_pkg::PowerBits-1:0] iir_power;
  logic [crms_pkg::AlphaBits-1:0] gain;

  // Expected RMS values, oldest first.
  logic [crms_pkg::RmsBits-1:0] rms_expect [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;

  complex_rms_estimator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .i_sample_i (i_sample_i),
    .q_sample_i (q_sample_i),
    .empty      (empty),
    .pop        (pop),
    .rms_out_o  (rms_out_o),
    .alpha_we_i (alpha_we_i),
    .alpha_i    (alpha_i)
  );

  // Free-running clock with a period of two units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Floor of the square root, one result bit per step from the top.
  function automatic logic [crms_pkg::RmsBits-1:0] floor_sqrt(
      input logic [crms_pkg::PowerBits-1:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = crms_pkg::RmsBits - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(x)) begin
        root = trial;
      end
    end
    return root[crms_pkg::RmsBits-1:0];
  endfunction

  // Advance the power filter by one sample and return the expected RMS value.
  function automatic logic [crms_pkg::RmsBits-1:0] advance_power(
      input logic signed [crms_pkg::SampleBits-1:0] i_s,
      input logic signed [crms_pkg::SampleBits-1:0] q_s);
    longint      i_w;
    longint      q_w;
    logic [63:0] magsq;
    logic [63:0] acc;
    i_w   = i_s;
    q_w   = q_s;
    magsq = 64'(i_w * i_w + q_w * q_w);
    acc   = 64'(iir_power) * (64'(crms_pkg::AlphaOne) - 64'(gain))
          + (magsq << crms_pkg::FracBits) * 64'(gain);
    iir_power = acc[63:crms_pkg::FracBits];
    return floor_sqrt(iir_power);
  endfunction

  // Send one sample beat, idling first at the current rate; push stays high afterwards.
  task automatic send_sample(input logic signed [crms_pkg::SampleBits-1:0] i_s,
                             input logic signed [crms_pkg::SampleBits-1:0] q_s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    i_sample_i <= i_s;
    q_sample_i <= q_s;
    do @(posedge clk_i); while (full);
    rms_expect.push_back(advance_power(i_s, q_s));
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic drain_results();
    push <= 1'b0;
    while (rms_expect.size() != 0) @(posedge clk_i);
  endtask

  // Write the gain register while the block is idle; values above one saturate.
  task automatic write_alpha(input logic [crms_pkg::AlphaBits-1:0] value);
    drain_results();
    alpha_we_i <= 1'b1;
    alpha_i    <= value;
    @(posedge clk_i);
    gain       = (value > crms_pkg::AlphaOne) ? crms_pkg::AlphaOne : value;
    alpha_we_i <= 1'b0;
  endtask

  // Random gain, with zero, unity and oversized values drawn often.
  function automatic logic [crms_pkg::AlphaBits-1:0] pick_alpha();
    case ($urandom_range(7))
      0:       return '0;
      1:       return crms_pkg::AlphaOne;
      2:       return (crms_pkg::AlphaBits)'($urandom_range(131071, 65537));
      3:       return (crms_pkg::AlphaBits)'(1);
      4:       return (crms_pkg::AlphaBits)'($urandom_range(255, 1));
      default: return (crms_pkg::AlphaBits)'($urandom_range(65535, 1));
    endcase
  endfunction

  // Random sample component: extremes, small values or the full range.
  function automatic logic signed [crms_pkg::SampleBits-1:0] pick_component();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return -32768;
          1:       return 32767;
          2:       return -1;
          3:       return 1;
          default: return 0;
        endcase
      end
      1, 2:    return (crms_pkg::SampleBits)'(int'($urandom_range(510)) - 255);
      default: return (crms_pkg::SampleBits)'($urandom);
    endcase
  endfunction

  // Directed beats: field extremes, reset gain, unity, saturation, hold and tiny gain.
  task automatic test_directed();
    send_sample(0, 0);
    send_sample(32767, 32767);
    send_sample(-32768, -32768);
    send_sample(-32768, 32767);
    send_sample(1, -1);
    // Unity gain follows the input; both components most negative give the top value.
    write_alpha(crms_pkg::AlphaOne);
    send_sample(-32768, -32768);
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(-1, 0);
    send_sample(0, -32768);
    // An oversized gain must behave as unity.
    write_alpha('1);
    send_sample(12345, -4321);
    send_sample(-32768, -32768);
    // Zero gain holds the power whatever comes in.
    write_alpha('0);
    send_sample(32767, 32767);
    send_sample(0, 0);
    send_sample(-32768, 1);
    // Smallest non-zero gain creeps slowly.
    write_alpha((crms_pkg::AlphaBits)'(1));
    send_sample(-32768, -32768);
    send_sample(32767, -32768);
    write_alpha((crms_pkg::AlphaBits)'(65535));
    send_sample(-32768, -32768);
    send_sample(0, 0);
  endtask

  // Random sample stream with the gain changed every hundred beats.
  task automatic test_random_stream(input int unsigned n_items,
                                    input int unsigned send_pct,
                                    input int unsigned recv_pct);
    drain_results();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        write_alpha(pick_alpha());
      end
      send_sample(pick_component(), pick_component());
    end
  endtask

  // Result side: pop at random and check each beat against the oldest expectation.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) begin
        if (rms_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("unexpected result beat: rms_out %0d", rms_out_o);
          end
        end else begin
          if (rms_out_o !== rms_expect[0]) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("rms_out mismatch: expected %0d, got %0d", rms_expect[0], rms_out_o);
            end
          end
          void'(rms_expect.pop_front());
        end
      end
    end
  end

  // Main sequence: reset, the tests in turn, then the final verdict.
  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    i_sample_i    = '0;
    q_sample_i    = '0;
    alpha_we_i    = 1'b0;
    alpha_i       = '0;
    iir_power     = '0;
    gain          = crms_pkg::AlphaReset;
    fail_count    = 0;
    send_idle_pct = 24;
    recv_idle_pct = 87;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stream(300, 24, 87);
    test_random_stream(300, 87, 24);
    test_random_stream(300, 0, 0);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && rms_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
